>>> rtl/mau_pkg.sv
// shared types and field widths of the modular arithmetic unit
`timescale 1ns / 1ps
package mau_pkg;

	localparam int OPA_W = 31;
	localparam int EXP_W = 63;
	localparam int RAW_W = 64;
	localparam int RES_W = 31;

	typedef enum logic [2:0] {
		OP_ADD    = 3'd0,
		OP_SUB    = 3'd1,
		OP_MUL    = 3'd2,
		OP_DIV    = 3'd3,
		OP_POW    = 3'd4,
		OP_NEG    = 3'd5,
		OP_REDUCE = 3'd6,
		OP_INV    = 3'd7
	} op_t;

endpackage

>>> rtl/mau_if.sv
// request, response and configuration channel interfaces
`timescale 1ns / 1ps
interface mau_req_if;
	logic                        valid;
	logic                        ready;
	mau_pkg::op_t                operation;
	logic [mau_pkg::OPA_W-1:0]   operand_a;
	logic [mau_pkg::OPA_W-1:0]   operand_b;
	logic [mau_pkg::EXP_W-1:0]   exponent;
	logic signed [mau_pkg::RAW_W-1:0] raw_value;
	modport source (output valid, operation, operand_a, operand_b, exponent, raw_value,
		input ready);
	modport sink (input valid, operation, operand_a, operand_b, exponent, raw_value,
		output ready);
endinterface

interface mau_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [mau_pkg::RES_W-1:0]   result;
	logic                        no_inverse;
	modport source (output valid, result, no_inverse, input ready);
	modport sink (input valid, result, no_inverse, output ready);
endinterface

interface mau_cfg_if #(parameter int MOD_BITS = 31);
	logic                valid;
	logic                ready;
	logic [MOD_BITS-1:0] modulus;
	modport source (output valid, modulus, input ready);
	modport sink (input valid, modulus, output ready);
endinterface

>>> rtl/modular_arithmetic_unit.sv
// modular arithmetic unit: bit-serial add, sub, mul, div, pow, neg, reduce, inverse
`timescale 1ns / 1ps
// One request at a time is taken while the unit is idle; a finished result sits in an
// output register, so the next request may be taken while it waits. The serial work
// goes one bit per cycle through a shift-subtract reducer and a shift-and-add modular
// multiplier (W = MOD_BITS). Every request except reduce first reduces both operands
// (unless the modulus is below 2); add, sub and neg then finish in the execute step and
// mul runs the multiplier once. Reduce skips the operand step and runs the reducer over
// all 64 bits of the raw value. Power, per exponent bit up to its highest set bit, does
// a multiply into the accumulator if the bit is set and then a squaring; inverse runs
// Euclid rounds, each a serial division plus a multiply, at most about 1.44*W+2 rounds;
// divide adds one more multiply. The modulus is written over the cfg channel (always
// ready, reset value 1000000007) and must stay fixed while requests are in flight.
module modular_arithmetic_unit #(
	parameter int MOD_BITS = 31
) (
	input  logic       clk,
	input  logic       arst_n,
	mau_req_if.sink    req,
	mau_rsp_if.source  rsp,
	mau_cfg_if.sink    cfg
);

	localparam int W = MOD_BITS;

	typedef enum logic [3:0] {
		S_IDLE, S_RA, S_RB, S_EXEC, S_EUC, S_EDIV, S_MUL, S_POW, S_RAW, S_FIN
	} state_t;

	// where the multiplier hands its product
	typedef enum logic [1:0] {R_RES, R_EUC, R_PACC, R_PBASE} ret_t;

	state_t             state_q;
	ret_t               ret_q;
	mau_pkg::op_t       op_q;
	logic [W-1:0]       mod_q;
	logic [W-1:0]       a_q, b_q;
	logic [mau_pkg::OPA_W-1:0] opb_q;
	logic [62:0]        exp_q;
	logic [63:0]        sh_q;
	logic [6:0]         cnt_q;
	logic [W-1:0]       rem_q, div_q, quo_q;
	logic [W-1:0]       macc_q, mx_q, my_q;
	logic [W-1:0]       r0_q, r1_q, t0_q, t1_q;
	logic [W-1:0]       pacc_q, pbase_q;
	logic               neg_q;
	logic [W-1:0]       res_q;
	logic               flag_q;
	logic               out_valid_q;
	logic [W-1:0]       out_res_q;
	logic               out_flag_q;

	// serial reducer step
	logic [W:0]   red_tmp;
	logic         red_ge;
	logic [W-1:0] red_nrem;
	// multiplier step
	logic [W-1:0] mul_nacc, mul_nmx;
	// quotient of the last division step
	logic [W-1:0] quo_fin, quo_mod;
	logic [63:0]  raw_mag;

	function automatic logic [W-1:0] addm(input logic [W-1:0] x, input logic [W-1:0] y,
		input logic [W-1:0] m);
		logic [W:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, m}) begin
			s = s - {1'b0, m};
		end
		return W'(s);
	endfunction

	function automatic logic [W-1:0] subm(input logic [W-1:0] x, input logic [W-1:0] y,
		input logic [W-1:0] m);
		logic [W-1:0] d;
		if (x >= y) begin
			d = x - y;
		end else begin
			d = x + (m - y);
		end
		return d;
	endfunction

	always_comb begin
		red_tmp  = {rem_q, sh_q[63]};
		red_ge   = red_tmp >= {1'b0, div_q};
		red_nrem = W'(red_ge ? red_tmp - {1'b0, div_q} : red_tmp);
		mul_nacc = my_q[0] ? addm(macc_q, mx_q, mod_q) : macc_q;
		mul_nmx  = addm(mx_q, mx_q, mod_q);
		quo_fin  = {quo_q[W-2:0], red_ge};
		quo_mod  = (quo_fin >= mod_q) ? quo_fin - mod_q : quo_fin;
		raw_mag  = req.raw_value[63] ? (~req.raw_value + 64'd1) : req.raw_value;
	end

	assign req.ready      = (state_q == S_IDLE);
	assign cfg.ready      = 1'b1;
	assign rsp.valid      = out_valid_q;
	assign rsp.result     = mau_pkg::RES_W'(out_res_q);
	assign rsp.no_inverse = out_flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			mod_q       <= W'(64'd1000000007);
		end else begin
			if (cfg.valid) begin
				mod_q <= cfg.modulus;
			end
			// in S_FIN the output register is refilled below
			if (rsp.valid && rsp.ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q   <= req.operation;
						exp_q  <= req.exponent;
						neg_q  <= req.raw_value[63];
						opb_q  <= req.operand_b;
						res_q  <= '0;
						flag_q <= 1'b0;
						if (mod_q < W'(2)) begin
							// degenerate modulus: everything is zero
							state_q <= S_FIN;
						end else if (req.operation == mau_pkg::OP_REDUCE) begin
							sh_q    <= raw_mag;
							rem_q   <= '0;
							div_q   <= mod_q;
							cnt_q   <= 7'd64;
							state_q <= S_RAW;
						end else begin
							sh_q    <= {req.operand_a, 33'b0};
							a_q     <= W'(req.operand_a);
							rem_q   <= '0;
							div_q   <= mod_q;
							cnt_q   <= 7'd31;
							state_q <= S_RA;
						end
					end
				end
				S_RA: begin
					sh_q  <= {sh_q[62:0], 1'b0};
					rem_q <= red_nrem;
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						a_q     <= red_nrem;
						sh_q    <= {opb_q, 33'b0};
						rem_q   <= '0;
						cnt_q   <= 7'd31;
						state_q <= S_RB;
					end
				end
				S_RB: begin
					sh_q  <= {sh_q[62:0], 1'b0};
					rem_q <= red_nrem;
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						b_q     <= red_nrem;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					unique case (op_q)
						mau_pkg::OP_ADD: begin
							res_q   <= addm(a_q, b_q, mod_q);
							state_q <= S_FIN;
						end
						mau_pkg::OP_SUB: begin
							res_q   <= subm(a_q, b_q, mod_q);
							state_q <= S_FIN;
						end
						mau_pkg::OP_NEG: begin
							res_q   <= subm('0, a_q, mod_q);
							state_q <= S_FIN;
						end
						mau_pkg::OP_MUL: begin
							macc_q  <= '0;
							mx_q    <= a_q;
							my_q    <= b_q;
							cnt_q   <= 7'(W);
							ret_q   <= R_RES;
							state_q <= S_MUL;
						end
						mau_pkg::OP_DIV, mau_pkg::OP_INV: begin
							// extended euclid on (modulus, value)
							r0_q    <= mod_q;
							r1_q    <= (op_q == mau_pkg::OP_DIV) ? b_q : a_q;
							t0_q    <= '0;
							t1_q    <= W'(1);
							state_q <= S_EUC;
						end
						mau_pkg::OP_POW: begin
							pacc_q  <= W'(1);
							pbase_q <= a_q;
							state_q <= S_POW;
						end
						mau_pkg::OP_REDUCE: begin
							state_q <= S_FIN;
						end
					endcase
				end
				S_EUC: begin
					if (r1_q == '0) begin
						if (r0_q != W'(1)) begin
							flag_q  <= 1'b1;
							res_q   <= '0;
							state_q <= S_FIN;
						end else if (op_q == mau_pkg::OP_DIV) begin
							macc_q  <= '0;
							mx_q    <= a_q;
							my_q    <= t0_q;
							cnt_q   <= 7'(W);
							ret_q   <= R_RES;
							state_q <= S_MUL;
						end else begin
							res_q   <= t0_q;
							state_q <= S_FIN;
						end
					end else begin
						sh_q    <= {r0_q, {(64-W){1'b0}}};
						rem_q   <= '0;
						div_q   <= r1_q;
						quo_q   <= '0;
						cnt_q   <= 7'(W);
						state_q <= S_EDIV;
					end
				end
				S_EDIV: begin
					sh_q  <= {sh_q[62:0], 1'b0};
					rem_q <= red_nrem;
					quo_q <= quo_fin;
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						r0_q    <= r1_q;
						r1_q    <= red_nrem;
						macc_q  <= '0;
						mx_q    <= t1_q;
						my_q    <= quo_mod;
						cnt_q   <= 7'(W);
						ret_q   <= R_EUC;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					macc_q <= mul_nacc;
					mx_q   <= mul_nmx;
					my_q   <= my_q >> 1;
					cnt_q  <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						unique case (ret_q)
							R_RES: begin
								res_q   <= mul_nacc;
								state_q <= S_FIN;
							end
							R_EUC: begin
								t0_q    <= t1_q;
								t1_q    <= subm(t0_q, mul_nacc, mod_q);
								state_q <= S_EUC;
							end
							R_PACC: begin
								pacc_q  <= mul_nacc;
								macc_q  <= '0;
								mx_q    <= pbase_q;
								my_q    <= pbase_q;
								cnt_q   <= 7'(W);
								ret_q   <= R_PBASE;
								state_q <= S_MUL;
							end
							R_PBASE: begin
								pbase_q <= mul_nacc;
								exp_q   <= exp_q >> 1;
								state_q <= S_POW;
							end
						endcase
					end
				end
				S_POW: begin
					macc_q <= '0;
					cnt_q  <= 7'(W);
					if (exp_q == '0) begin
						res_q   <= pacc_q;
						state_q <= S_FIN;
					end else if (exp_q[0]) begin
						mx_q    <= pacc_q;
						my_q    <= pbase_q;
						ret_q   <= R_PACC;
						state_q <= S_MUL;
					end else begin
						mx_q    <= pbase_q;
						my_q    <= pbase_q;
						ret_q   <= R_PBASE;
						state_q <= S_MUL;
					end
				end
				S_RAW: begin
					sh_q  <= {sh_q[62:0], 1'b0};
					rem_q <= red_nrem;
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						// negative input folds back from the modulus
						res_q   <= (neg_q && red_nrem != '0) ? mod_q - red_nrem : red_nrem;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_res_q   <= res_q;
						out_flag_q  <= flag_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_flag_q |-> out_res_q == '0)
		else $error("no_inverse with nonzero result");

	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && mod_q >= W'(2) |-> out_res_q < mod_q)
		else $error("result not below modulus");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("second request taken while busy");

	a_flag_ops: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN && flag_q |-> op_q == mau_pkg::OP_DIV || op_q == mau_pkg::OP_INV)
		else $error("flag raised by an operation without inverse");
`endif

endmodule

>>> bench/mau_result_checker.sv
// result checker for the modular arithmetic unit: predicts each request and compares
`timescale 1ns / 1ps
module mau_result_checker (
	input  logic clk,
	input  logic arst_n,
	mau_req_if   req,
	mau_rsp_if   rsp,
	mau_cfg_if   cfg,
	output int   error_count,
	output int   outstanding
);

	typedef struct packed {
		logic [mau_pkg::RES_W-1:0] residue;
		logic                      no_inverse;
	} residue_t;

	residue_t       expected_results[$];
	logic [63:0]    modulus;

	function automatic residue_t predict_residue(mau_pkg::op_t op, logic [63:0] m,
			logic [mau_pkg::OPA_W-1:0] opa, logic [mau_pkg::OPA_W-1:0] opb,
			logic [mau_pkg::EXP_W-1:0] e, logic [mau_pkg::RAW_W-1:0] raw);
		residue_t    r;
		logic [63:0] a, b, acc, base, mag;
		longint      r0, r1, r2, t0, t1, t2, q;
		logic        invertible;
		r = '0;
		if (m < 2)
			return r;
		a = {33'd0, opa} % m;
		b = {33'd0, opb} % m;
		// extended euclid on the divisor or the value to invert
		r0 = m;
		r1 = (op == mau_pkg::OP_DIV) ? b : a;
		t0 = 0;
		t1 = 1;
		while (r1 != 0) begin
			q = r0 / r1;
			r2 = r0 - q * r1;
			t2 = t0 - q * t1;
			r0 = r1; r1 = r2;
			t0 = t1; t1 = t2;
		end
		invertible = (r0 == 1);
		if (t0 < 0)
			t0 = t0 + longint'(m);
		case (op)
			mau_pkg::OP_ADD: acc = (a + b) % m;
			mau_pkg::OP_SUB: acc = (a + m - b) % m;
			mau_pkg::OP_MUL: acc = (a * b) % m;
			mau_pkg::OP_DIV: acc = invertible ? (a * t0) % m : 0;
			mau_pkg::OP_POW: begin
				acc = 1;
				base = a;
				while (e != 0) begin
					if (e[0])
						acc = (acc * base) % m;
					base = (base * base) % m;
					e = e >> 1;
				end
			end
			mau_pkg::OP_NEG: acc = (m - a) % m;
			mau_pkg::OP_REDUCE: begin
				if (raw[63]) begin
					mag = ~raw + 64'd1;
					acc = (mag % m == 0) ? 0 : m - (mag % m);
				end else begin
					acc = raw % m;
				end
			end
			default: acc = invertible ? t0 : 0;
		endcase
		r.residue = acc[mau_pkg::RES_W-1:0];
		r.no_inverse = (op == mau_pkg::OP_DIV || op == mau_pkg::OP_INV) && !invertible;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		residue_t want;
		bit       popped;
		if (!arst_n) begin
			modulus <= 64'd1000000007;
			error_count <= 0;
			outstanding <= 0;
			expected_results.delete();
		end else begin
			popped = 1'b0;
			if (cfg.valid && cfg.ready)
				modulus <= {33'd0, cfg.modulus};
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result %0d/%0d with no request pending", $time,
						rsp.result, rsp.no_inverse);
					error_count <= error_count + 1;
				end else begin
					want = expected_results.pop_front();
					popped = 1'b1;
					if (rsp.result !== want.residue || rsp.no_inverse !== want.no_inverse) begin
						$display("%0t: expected result %0d no_inverse %0d, got %0d %0d",
							$time, want.residue, want.no_inverse, rsp.result,
							rsp.no_inverse);
						error_count <= error_count + 1;
					end
				end
			end
			if (req.valid && req.ready)
				expected_results.push_back(predict_residue(req.operation, modulus,
					req.operand_a, req.operand_b, req.exponent, req.raw_value));
			outstanding <= outstanding + int'(req.valid && req.ready) - int'(popped);
		end
	end
endmodule

>>> bench/modular_arithmetic_unit_test.sv
// top of the modular arithmetic unit testbench: stimulus, stalls and verdict
`timescale 1ns / 1ps
module modular_arithmetic_unit_test;

	localparam int CYCLE_LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   error_count;
	int   outstanding;
	int   cycle_count = 0;
	bit   idle_en = 1'b1;     // random bursts of idling on both sides
	bit   hold_off = 1'b0;    // asks the receiver for one long stall
	logic [30:0] cur_mod = 31'd1000000007;

	mau_req_if req ();
	mau_rsp_if rsp ();
	mau_cfg_if #(.MOD_BITS(31)) cfg ();

	modular_arithmetic_unit #(.MOD_BITS(31)) dut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg)
	);

	mau_result_checker chk (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg),
		.error_count(error_count), .outstanding(outstanding)
	);

	always #5 clk = ~clk;

	// watchdog on total run length
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("modular_arithmetic_unit_test: errors");
			$finish;
		end
	end

	// response side: random back-pressure, plus one long hold so requests back up
	initial begin
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				rsp.ready <= 1'b0;
				repeat (600) @(posedge clk);
				hold_off = 1'b0;
			end else if (idle_en && $urandom_range(0, 3) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				rsp.ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	// one request; valid is dropped only when a gap comes first
	task automatic send_request(input mau_pkg::op_t op, input logic [30:0] a,
			input logic [30:0] b, input logic [62:0] e, input logic [63:0] raw);
		int gap;
		gap = (idle_en && $urandom_range(0, 2) == 0) ? $urandom_range(1, 18) : 0;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.operation <= op;
		req.operand_a <= a;
		req.operand_b <= b;
		req.exponent <= e;
		req.raw_value <= raw;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain;
		req.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// modulus write, only with the unit idle
	task automatic write_modulus(input logic [30:0] m);
		drain();
		cfg.valid <= 1'b1;
		cfg.modulus <= m;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		cur_mod = m;
	endtask

	function automatic logic [30:0] pick_operand;
		case ($urandom_range(0, 5))
			0: return 31'($urandom_range(0, 3));
			1: return (cur_mod > 1) ? cur_mod - 31'($urandom_range(1, 2)) : 31'd0;
			2: return (cur_mod > 1) ? 31'($urandom_range(0, cur_mod - 1)) : 31'd0;
			default: return 31'($urandom);
		endcase
	endfunction

	task automatic random_requests(input int n);
		logic [62:0] e;
		repeat (n) begin
			// mostly short exponents keep power requests quick
			if ($urandom_range(0, 9) == 0)
				e = 63'({$urandom, $urandom});
			else
				e = 63'($urandom_range(0, 1 << $urandom_range(0, 16)));
			send_request(mau_pkg::op_t'(3'($urandom_range(0, 7))), pick_operand(),
				pick_operand(), e, {$urandom, $urandom});
		end
	endtask

	initial begin
		req.valid = 1'b0;
		req.operation = mau_pkg::OP_ADD;
		req.operand_a = '0;
		req.operand_b = '0;
		req.exponent = '0;
		req.raw_value = '0;
		cfg.valid = 1'b0;
		cfg.modulus = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners on the reset modulus
		send_request(mau_pkg::OP_ADD, 31'h7fffffff, 31'h7fffffff, '0, '0);
		send_request(mau_pkg::OP_ADD, 31'd1000000006, 31'd1000000006, '0, '0);
		send_request(mau_pkg::OP_SUB, 31'd0, 31'd1, '0, '0);
		send_request(mau_pkg::OP_SUB, 31'd77, 31'd77, '0, '0);
		send_request(mau_pkg::OP_MUL, 31'd1000000006, 31'd1000000006, '0, '0);
		send_request(mau_pkg::OP_MUL, 31'd0, 31'h7fffffff, '0, '0);
		send_request(mau_pkg::OP_DIV, 31'd5, 31'd0, '0, '0);
		send_request(mau_pkg::OP_DIV, 31'd123456, 31'd789, '0, '0);
		send_request(mau_pkg::OP_DIV, 31'd42, 31'd1, '0, '0);
		send_request(mau_pkg::OP_POW, 31'd0, 31'd0, 63'd0, '0);
		send_request(mau_pkg::OP_POW, 31'd5, 31'd0, 63'd0, '0);
		send_request(mau_pkg::OP_POW, 31'd2, 31'd0, {63{1'b1}}, '0);
		send_request(mau_pkg::OP_POW, 31'd3, 31'd0, 63'd1000000005, '0);
		send_request(mau_pkg::OP_POW, 31'd0, 31'd0, 63'd5, '0);
		send_request(mau_pkg::OP_NEG, 31'd0, 31'd0, '0, '0);
		send_request(mau_pkg::OP_NEG, 31'd1, 31'd0, '0, '0);
		send_request(mau_pkg::OP_NEG, 31'h7fffffff, 31'd0, '0, '0);
		send_request(mau_pkg::OP_REDUCE, 31'd0, 31'd0, '0, 64'h8000000000000000);
		send_request(mau_pkg::OP_REDUCE, 31'd0, 31'd0, '0, 64'h7fffffffffffffff);
		send_request(mau_pkg::OP_REDUCE, 31'd0, 31'd0, '0, {64{1'b1}});
		send_request(mau_pkg::OP_REDUCE, 31'd0, 31'd0, '0, 64'd0);
		send_request(mau_pkg::OP_INV, 31'd0, 31'd0, '0, '0);
		send_request(mau_pkg::OP_INV, 31'd1, 31'd0, '0, '0);
		send_request(mau_pkg::OP_INV, 31'd1000000006, 31'd0, '0, '0);
		send_request(mau_pkg::OP_INV, 31'h7fffffff, 31'd0, '0, '0);

		// largest modulus
		write_modulus(31'h7fffffff);
		random_requests(25);
		// smallest useful modulus
		write_modulus(31'd2);
		random_requests(12);
		// degenerate moduli give zero everywhere
		write_modulus(31'd0);
		random_requests(6);
		write_modulus(31'd1);
		random_requests(6);
		// composite modulus: many values lack an inverse; long receiver hold here
		write_modulus(31'd12);
		hold_off = 1'b1;
		random_requests(25);
		write_modulus(31'($urandom_range(3, 31'h7fffffff)) | 31'd1);
		random_requests(25);
		// closing stretch with no idling
		write_modulus(31'd1000000007);
		idle_en = 1'b0;
		random_requests(20);

		drain();
		repeat (50) @(posedge clk);
		if (error_count == 0) begin
			$display("modular_arithmetic_unit_test: clean");
		end else begin
			$display("modular_arithmetic_unit_test: errors");
		end
		$finish;
	end
endmodule
